// ===== rtl/vtyp_pkg.sv =====
// Shared types, constants and the arctangent table for the vector-to-angles pipeline.
// Depends on nothing; every other file imports this package.
package vtyp_pkg;

  // Field widths and pipeline depth.
  localparam int COMPONENT_WIDTH     = 16;
  localparam int ANGLE_FRACTION_BITS = 8;
  localparam int CORDIC_STAGES       = 16;

  // Internal datapath: normalized components stay below 2^41 and grow by the
  // CORDIC gain, so 48 bits hold every intermediate value.
  localparam int DataWidth  = 48;
  // Angle accumulator: signed degrees with 24 fraction bits, range about -100..280.
  localparam int AccFrac    = 24;
  localparam int AngleWidth = 34;
  localparam int OutWidth   = 9 + ANGLE_FRACTION_BITS;

  // Normalization brings the largest component to at least 2^NormExp.
  localparam int NormExp    = 40;
  localparam int ShiftWidth = $clog2(NormExp + 1);
  localparam int MsbWidth   = $clog2(COMPONENT_WIDTH);

  // Inverse CORDIC gain in Q31 and the split used for the exact product.
  localparam longint GainTail  = (2 * CORDIC_STAGES <= 62) ?
                                 (longint'(869377165) >> (2 * CORDIC_STAGES)) : 0;
  localparam longint GainValue = longint'(1304065748) + GainTail;
  localparam int     GainWidth = 31;
  localparam int     GainSplit = 21;
  localparam int     GainShift = 10;

  typedef logic signed [DataWidth-1:0]  data_t;
  typedef logic signed [AngleWidth-1:0] angle_t;

  localparam angle_t AngleHalf = angle_t'(longint'(180) << AccFrac);
  localparam angle_t AngleFull = angle_t'(longint'(360) << AccFrac);

  // Everything that rides along with an item beside the CORDIC vector.
  typedef struct packed {
    logic   special;  // x and y both zero: fixed answer, CORDIC result ignored
    logic   z_pos;    // z strictly positive
    data_t  zn;       // normalized z, the y input of the pitch pass
    angle_t yaw;      // yaw angle once the first pass is done
  } side_t;

  // round(atan(2^-i) * 180/pi * 2^24).
  function automatic logic [29:0] atan_entry(input int idx);
    logic [29:0] v;
    begin
      case (idx)
        0:  v = 30'd754974720;
        1:  v = 30'd445687602;
        2:  v = 30'd235489088;
        3:  v = 30'd119537938;
        4:  v = 30'd60000934;
        5:  v = 30'd30029717;
        6:  v = 30'd15018523;
        7:  v = 30'd7509720;
        8:  v = 30'd3754917;
        9:  v = 30'd1877466;
        10: v = 30'd938734;
        11: v = 30'd469367;
        12: v = 30'd234684;
        13: v = 30'd117342;
        14: v = 30'd58671;
        15: v = 30'd29335;
        16: v = 30'd14668;
        17: v = 30'd7334;
        18: v = 30'd3667;
        19: v = 30'd1833;
        20: v = 30'd917;
        21: v = 30'd458;
        22: v = 30'd229;
        23: v = 30'd115;
        24: v = 30'd57;
        25: v = 30'd29;
        26: v = 30'd14;
        27: v = 30'd7;
        28: v = 30'd4;
        29: v = 30'd2;
        30: v = 30'd1;
        default: v = 30'd0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== rtl/vtyp_norm.sv =====
// Front end: finds the common normalizing shift, scales the components and
// folds a negative x into the right half plane. Two register stages. Uses vtyp_pkg.
module vtyp_norm import vtyp_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [COMPONENT_WIDTH-1:0] x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] z_i,
  output logic                              valid_o,
  output data_t                             x_o,
  output data_t                             y_o,
  output angle_t                            ang_o,
  output side_t                             side_o
);

  logic [COMPONENT_WIDTH-1:0] mag_x, mag_y, mag_z, mag_or;
  logic [MsbWidth-1:0]        msb;
  logic [ShiftWidth-1:0]      shift_d;

  logic                              v1_q;
  logic signed [COMPONENT_WIDTH-1:0] x1_q, y1_q, z1_q;
  logic [ShiftWidth-1:0]             shift_q;
  logic                              special_q, z_pos_q;

  data_t xs, ys, zs;
  logic  neg;

  logic   v2_q;
  data_t  x2_q, y2_q;
  angle_t ang2_q;
  side_t  side2_q;

  // The largest magnitude has the same leading one as the OR of all three.
  assign mag_x  = x_i[COMPONENT_WIDTH-1] ? (~x_i + 1'b1) : x_i;
  assign mag_y  = y_i[COMPONENT_WIDTH-1] ? (~y_i + 1'b1) : y_i;
  assign mag_z  = z_i[COMPONENT_WIDTH-1] ? (~z_i + 1'b1) : z_i;
  assign mag_or = mag_x | mag_y | mag_z;

  // Leading-one position picks the shift that lands the maximum in [2^40, 2^41).
  always_comb begin
    msb = '0;
    for (int b = 0; b < COMPONENT_WIDTH; b++) begin
      if (mag_or[b]) msb = MsbWidth'(b);
    end
    shift_d = ShiftWidth'(NormExp) - ShiftWidth'(msb);
  end

  // Stage one: raw components, shift amount and the special-case flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      x1_q      <= x_i;
      y1_q      <= y_i;
      z1_q      <= z_i;
      shift_q   <= shift_d;
      special_q <= (x_i == '0) && (y_i == '0);
      z_pos_q   <= !z_i[COMPONENT_WIDTH-1] && (z_i != '0);
    end
  end

  // Scale, then rotate by 180 degrees when x is negative.
  assign xs  = data_t'(x1_q) <<< shift_q;
  assign ys  = data_t'(y1_q) <<< shift_q;
  assign zs  = data_t'(z1_q) <<< shift_q;
  assign neg = x1_q[COMPONENT_WIDTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      x2_q            <= neg ? -xs : xs;
      y2_q            <= neg ? -ys : ys;
      ang2_q          <= neg ? AngleHalf : '0;
      side2_q.special <= special_q;
      side2_q.z_pos   <= z_pos_q;
      side2_q.zn      <= zs;
      side2_q.yaw     <= '0;
    end
  end

  assign valid_o = v2_q;
  assign x_o     = x2_q;
  assign y_o     = y2_q;
  assign ang_o   = ang2_q;
  assign side_o  = side2_q;

endmodule

// ===== rtl/vtyp_cordic_pass.sv =====
// One CORDIC vectoring pass: CORDIC_STAGES register stages, each one
// micro-rotation that drives y toward zero. Uses vtyp_pkg for types and the table.
module vtyp_cordic_pass import vtyp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  data_t  x_i,
  input  data_t  y_i,
  input  angle_t ang_i,
  input  side_t  side_i,
  output logic   valid_o,
  output data_t  x_o,
  output data_t  y_o,
  output angle_t ang_o,
  output side_t  side_o
);

  logic   vs [CORDIC_STAGES+1];
  data_t  xs [CORDIC_STAGES+1];
  data_t  ys [CORDIC_STAGES+1];
  angle_t as [CORDIC_STAGES+1];
  side_t  ss [CORDIC_STAGES+1];

  assign vs[0] = valid_i;
  assign xs[0] = x_i;
  assign ys[0] = y_i;
  assign as[0] = ang_i;
  assign ss[0] = side_i;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    data_t  dx, dy;
    angle_t step;
    logic   turn_cw;
    logic   v_q;
    data_t  x_q, y_q;
    angle_t a_q;
    side_t  s_q;

    // Arithmetic shifts floor toward minus infinity.
    assign dx      = ys[g] >>> g;
    assign dy      = xs[g] >>> g;
    assign step    = angle_t'(atan_entry(g));
    assign turn_cw = !ys[g][DataWidth-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else begin
        v_q <= vs[g];
      end
    end

    // Turn clockwise while y is non-negative, otherwise counter-clockwise.
    always_ff @(posedge clk_i) begin
      if (vs[g]) begin
        if (turn_cw) begin
          x_q <= xs[g] + dx;
          y_q <= ys[g] - dy;
          a_q <= as[g] + step;
        end else begin
          x_q <= xs[g] - dx;
          y_q <= ys[g] + dy;
          a_q <= as[g] - step;
        end
        s_q <= ss[g];
      end
    end

    assign vs[g+1] = v_q;
    assign xs[g+1] = x_q;
    assign ys[g+1] = y_q;
    assign as[g+1] = a_q;
    assign ss[g+1] = s_q;
  end

  assign valid_o = vs[CORDIC_STAGES];
  assign x_o     = xs[CORDIC_STAGES];
  assign y_o     = ys[CORDIC_STAGES];
  assign ang_o   = as[CORDIC_STAGES];
  assign side_o  = ss[CORDIC_STAGES];

endmodule

// ===== rtl/vtyp_gain.sv =====
// Gain compensation of the first-pass magnitude: floor(r * G / 2^31), exact,
// from two partial products over three register stages. Uses vtyp_pkg.
module vtyp_gain import vtyp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  data_t r_i,
  input  side_t side_i,
  output logic  valid_o,
  output data_t rc_o,
  output side_t side_o
);

  localparam int HiWidth  = DataWidth - 1 - GainSplit;
  localparam int LoProdW  = GainSplit + GainWidth;
  localparam int HiProdW  = HiWidth + GainWidth;
  localparam int SumWidth = DataWidth + GainShift;

  localparam logic [GainWidth-1:0] Gain = GainWidth'(GainValue);

  data_t                r;
  logic [HiWidth-1:0]   r_hi;
  logic [GainSplit-1:0] r_lo;
  logic [SumWidth-1:0]  sum;

  logic                  v1_q, v2_q, v3_q;
  logic [HiWidth-1:0]    hi1_q;
  logic [LoProdW-1:0]    plo1_q;
  logic [GainWidth-1:0]  plo2_q;
  logic [HiProdW-1:0]    phi2_q;
  data_t                 rc3_q;
  side_t                 s1_q, s2_q, s3_q;

  // The magnitude is never negative in practice; clamp it anyway.
  assign r    = r_i[DataWidth-1] ? '0 : r_i;
  assign r_hi = r[DataWidth-2:GainSplit];
  assign r_lo = r[GainSplit-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage one: low partial product.
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      plo1_q <= LoProdW'(r_lo) * LoProdW'(Gain);
      hi1_q  <= r_hi;
      s1_q   <= side_i;
    end
  end

  // Stage two: high partial product; the low one keeps only its top bits.
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      phi2_q <= HiProdW'(hi1_q) * HiProdW'(Gain);
      plo2_q <= plo1_q[LoProdW-1:GainSplit];
      s2_q   <= s1_q;
    end
  end

  // Stage three: combine and drop the remaining fraction bits.
  assign sum = SumWidth'(phi2_q) + SumWidth'(plo2_q);

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      rc3_q <= data_t'(sum[GainShift +: DataWidth]);
      s3_q  <= s2_q;
    end
  end

  assign valid_o = v3_q;
  assign rc_o    = rc3_q;
  assign side_o  = s3_q;

endmodule

// ===== rtl/vector_to_yaw_pitch_top.sv =====
// Top level of the vector-to-angles pipeline: front end, two CORDIC passes,
// gain compensation and the output rounding stage. Uses vtyp_pkg and all vtyp_* modules.
//
// The block turns a signed 3-D vector into yaw = atan2(y, x) and
// pitch = atan2(z, sqrt(x*x + y*y)), both in degrees with eight fraction bits
// and wrapped into 0 to under 360. It is a fully pipelined datapath: a new item
// is taken in every clock cycle, so busy is always low. Each item passes through
// two normalization stages, a first chain of CORDIC stages, three stages of gain
// multiply, a second chain of CORDIC stages (one micro-rotation per register in
// both chains) and one rounding stage before its result appears on done_o.
// Results leave in input order and are shown for one cycle only; the receiver must
// take them as they come.
module vector_to_yaw_pitch_top import vtyp_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COMPONENT_WIDTH-1:0] x_component_i,
  input  logic signed [COMPONENT_WIDTH-1:0] y_component_i,
  input  logic signed [COMPONENT_WIDTH-1:0] z_component_i,
  output logic                              done_o,
  output logic [OutWidth-1:0]               yaw_degrees_o,
  output logic [OutWidth-1:0]               pitch_degrees_o
);

  localparam int RoundShift = AccFrac - ANGLE_FRACTION_BITS;
  localparam logic [AngleWidth-1:0] RoundHalf = AngleWidth'(longint'(1) << (RoundShift - 1));
  localparam logic [OutWidth-1:0] OutLimit  = OutWidth'(360 << ANGLE_FRACTION_BITS);
  localparam logic [OutWidth-1:0] PitchUp   = OutWidth'(90 << ANGLE_FRACTION_BITS);
  localparam logic [OutWidth-1:0] PitchDown = OutWidth'(270 << ANGLE_FRACTION_BITS);

  logic   accept;
  logic   n_valid, p1_valid, g_valid, p2_valid;
  data_t  n_x, n_y, p1_x, p1_y, g_rc, p2_x, p2_y;
  angle_t n_ang, p1_ang, p2_ang;
  side_t  n_side, p1_side, g_side_in, g_side, p2_side;

  logic                done_q;
  logic [OutWidth-1:0] yaw_q, pitch_q;

  // Wrap into [0, 360) degrees, round half up, fold an exact 360 back to 0.
  function automatic logic [OutWidth-1:0] to_degrees(input angle_t a);
    angle_t                w;
    logic [AngleWidth-1:0] sum;
    logic [OutWidth-1:0]   q;
    begin
      w = a;
      if (w < 0) begin
        w = w + AngleFull;
      end else if (w >= AngleFull) begin
        w = w - AngleFull;
      end
      sum = AngleWidth'(w) + RoundHalf;
      q   = sum[RoundShift +: OutWidth];
      if (q >= OutLimit) q = q - OutLimit;
      return q;
    end
  endfunction

  // The pipeline never stalls, so every start is an accepted item.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  vtyp_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .x_i     (x_component_i),
    .y_i     (y_component_i),
    .z_i     (z_component_i),
    .valid_o (n_valid),
    .x_o     (n_x),
    .y_o     (n_y),
    .ang_o   (n_ang),
    .side_o  (n_side)
  );

  // First pass: (x, y) onto the x axis gives yaw and the raw magnitude.
  vtyp_cordic_pass u_yaw_pass (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (n_valid),
    .x_i     (n_x),
    .y_i     (n_y),
    .ang_i   (n_ang),
    .side_i  (n_side),
    .valid_o (p1_valid),
    .x_o     (p1_x),
    .y_o     (p1_y),
    .ang_o   (p1_ang),
    .side_o  (p1_side)
  );

  // Park the yaw angle in the side data for the rest of the trip.
  always_comb begin
    g_side_in     = p1_side;
    g_side_in.yaw = p1_ang;
  end

  vtyp_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p1_valid),
    .r_i     (p1_x),
    .side_i  (g_side_in),
    .valid_o (g_valid),
    .rc_o    (g_rc),
    .side_o  (g_side)
  );

  // Second pass: (magnitude, z) onto the x axis gives pitch.
  vtyp_cordic_pass u_pitch_pass (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g_valid),
    .x_i     (g_rc),
    .y_i     (g_side.zn),
    .ang_i   ('0),
    .side_i  (g_side),
    .valid_o (p2_valid),
    .x_o     (p2_x),
    .y_o     (p2_y),
    .ang_o   (p2_ang),
    .side_o  (p2_side)
  );

  // Output stage: rounding, and the fixed answer when x and y are both zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= p2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_valid) begin
      if (p2_side.special) begin
        yaw_q   <= '0;
        pitch_q <= p2_side.z_pos ? PitchUp : PitchDown;
      end else begin
        yaw_q   <= to_degrees(p2_side.yaw);
        pitch_q <= to_degrees(p2_ang);
      end
    end
  end

  assign done_o          = done_q;
  assign yaw_degrees_o   = yaw_q;
  assign pitch_degrees_o = pitch_q;

  // The residual y values and final x of the second pass carry no result.
  logic unused_residue;
  assign unused_residue = ^{p1_y, p2_x, p2_y};

endmodule

// ===== tb/tb_vector_to_yaw_pitch_top.sv =====
// Self-checking testbench for vector_to_yaw_pitch_top: random and directed vectors in,
// yaw and pitch compared against an in-bench fixed-point CORDIC predictor.
// Depends on vtyp_pkg and the vector_to_yaw_pitch_top RTL.
module tb_vector_to_yaw_pitch_top;
  import vtyp_pkg::*;

  // Bench constants for the predictor and the run.
  localparam int     AccFracBits   = 24;
  localparam int     NormFloorExp  = 40;
  localparam longint GainInfQ31    = 64'd1304065748;
  localparam longint GainTailQ31   = 64'd869377165;
  localparam int     ResultLatency = 2 * CORDIC_STAGES + 6;
  localparam int     WatchdogLimit = 2000;
  localparam int     RandomItems   = 930;

  // round(atan(2^-i) * 180/pi * 2^24) per micro-rotation.
  localparam longint AtanDeg [32] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0
  };

  typedef struct {
    logic signed [COMPONENT_WIDTH-1:0] x;
    logic signed [COMPONENT_WIDTH-1:0] y;
    logic signed [COMPONENT_WIDTH-1:0] z;
  } vec_t;

  typedef struct {
    vec_t                src;
    logic [OutWidth-1:0] yaw;
    logic [OutWidth-1:0] pitch;
  } pred_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic signed [COMPONENT_WIDTH-1:0] x_component_i = '0;
  logic signed [COMPONENT_WIDTH-1:0] y_component_i = '0;
  logic signed [COMPONENT_WIDTH-1:0] z_component_i = '0;
  logic                              done_o;
  logic [OutWidth-1:0]               yaw_degrees_o;
  logic [OutWidth-1:0]               pitch_degrees_o;

  vec_t    vec_pending[$];
  pred_t   angle_q[$];
  vec_t    vec_on_port;
  pred_t   angle_exp;
  int      gap_left = 0;
  bit      no_idle = 1'b0;
  int      idle_cycles = 0;
  int      err_cnt = 0;

  vector_to_yaw_pitch_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .x_component_i   (x_component_i),
    .y_component_i   (y_component_i),
    .z_component_i   (z_component_i),
    .done_o          (done_o),
    .yaw_degrees_o   (yaw_degrees_o),
    .pitch_degrees_o (pitch_degrees_o)
  );

  // Clock with a period of 4.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Vectoring pass: rotates (px, py) onto the positive x axis, returns the angle turned.
  function automatic longint rotate_to_axis(inout longint px, inout longint py);
    longint acc;
    longint dx;
    longint dy;
    begin
      acc = 0;
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
        dx = py >>> i;
        dy = px >>> i;
        if (py >= 0) begin
          px  = px + dx;
          py  = py - dy;
          acc = acc + AtanDeg[i];
        end else begin
          px  = px - dx;
          py  = py + dy;
          acc = acc - AtanDeg[i];
        end
      end
      return acc;
    end
  endfunction

  // Wraps an accumulator angle into one turn and rounds half up to the output format.
  function automatic logic [OutWidth-1:0] wrap_round(input longint a);
    longint full;
    longint unsigned q;
    longint unsigned lim;
    begin
      full = longint'(360) <<< AccFracBits;
      lim  = longint'(360) << ANGLE_FRACTION_BITS;
      if (a < 0) a = a + full;
      if (a < 0) a = a + full;
      if (a >= full) a = a - full;
      if (a >= full) a = a - full;
      q = (longint'(a) + (64'd1 << (AccFracBits - ANGLE_FRACTION_BITS - 1)))
          >> (AccFracBits - ANGLE_FRACTION_BITS);
      if (q >= lim) q = q - lim;
      return q[OutWidth-1:0];
    end
  endfunction

  // Expected yaw and pitch of one vector.
  function automatic pred_t compute_angles(input vec_t v);
    longint xs, ys, zs, xn, yn, zn, xp, yaw_acc, pitch_acc;
    longint unsigned mag, r, rh, rl, rc, gain;
    int sh;
    pred_t res;
    begin
      res.src = v;
      xs = longint'(v.x);
      ys = longint'(v.y);
      zs = longint'(v.z);
      // No planar part: fixed answer straight up or straight down.
      if (xs == 0 && ys == 0) begin
        res.yaw   = '0;
        res.pitch = (zs > 0) ? OutWidth'(90 << ANGLE_FRACTION_BITS)
                             : OutWidth'(270 << ANGLE_FRACTION_BITS);
        return res;
      end
      // Normalize all three by a common left shift.
      mag = (xs < 0) ? -xs : xs;
      if (((ys < 0) ? -ys : ys) > mag) mag = (ys < 0) ? -ys : ys;
      if (((zs < 0) ? -zs : zs) > mag) mag = (zs < 0) ? -zs : zs;
      sh = 0;
      while (mag < (64'd1 << NormFloorExp) && sh < 62) begin
        mag = mag << 1;
        sh++;
      end
      xn = xs <<< sh;
      yn = ys <<< sh;
      zn = zs <<< sh;
      // Left half plane: mirror through the origin and start at 180 degrees.
      yaw_acc = 0;
      if (xn < 0) begin
        xn = -xn;
        yn = -yn;
        yaw_acc = longint'(180) <<< AccFracBits;
      end
      yaw_acc = yaw_acc + rotate_to_axis(xn, yn);
      // Gain-compensate the planar magnitude with a split exact multiply.
      gain = GainInfQ31 + ((CORDIC_STAGES <= 31) ? (GainTailQ31 >> (2 * CORDIC_STAGES)) : 0);
      r  = (xn < 0) ? 64'd0 : xn;
      rh = r >> 21;
      rl = r & ((64'd1 << 21) - 1);
      rc = (rh * gain + ((rl * gain) >> 21)) >> 10;
      xp = rc;
      pitch_acc = rotate_to_axis(xp, zn);
      res.yaw   = wrap_round(yaw_acc);
      res.pitch = wrap_round(pitch_acc);
      return res;
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    err_cnt++;
  endtask

  function automatic logic signed [COMPONENT_WIDTH-1:0] rand_component();
    logic signed [COMPONENT_WIDTH-1:0] c;
    logic [31:0] r;
    int sel;
    begin
      sel = $urandom_range(0, 9);
      r   = $urandom();
      case (sel)
        0: c = '0;
        1: c = COMPONENT_WIDTH'(int'($urandom_range(0, 16)) - 8);
        2: begin
          case ($urandom_range(0, 3))
            0: c = {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};
            1: c = {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
            2: c = '1;
            default: c = COMPONENT_WIDTH'(1);
          endcase
        end
        default: c = r[COMPONENT_WIDTH-1:0];
      endcase
      return c;
    end
  endfunction

  // Idle gap before the next item: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    begin
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
    end
  endfunction

  function automatic void add_vector(input int xv, input int yv, input int zv);
    vec_t v;
    begin
      v.x = COMPONENT_WIDTH'(xv);
      v.y = COMPONENT_WIDTH'(yv);
      v.z = COMPONENT_WIDTH'(zv);
      vec_pending.push_back(v);
    end
  endfunction

  // Driver: predicts each accepted item and presents the next one after its gap.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        angle_q.push_back(compute_angles(vec_on_port));
      end
      if (!start || !busy) begin
        if ($urandom_range(0, 49) == 0) no_idle = ~no_idle;
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (vec_pending.size() > 0) begin
          vec_on_port = vec_pending.pop_front();
          x_component_i <= vec_on_port.x;
          y_component_i <= vec_on_port.y;
          z_component_i <= vec_on_port.z;
          start <= 1'b1;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o !== 1'b0 && done_o !== 1'b1) begin
        report_mismatch("done_o is unknown");
      end else if (done_o) begin
        if (angle_q.size() == 0) begin
          report_mismatch($sformatf("result with no item pending: yaw=%0d pitch=%0d",
                                    yaw_degrees_o, pitch_degrees_o));
        end else begin
          angle_exp = angle_q.pop_front();
          if (yaw_degrees_o !== angle_exp.yaw)
            report_mismatch($sformatf("yaw for (%0d,%0d,%0d): got %0d, want %0d",
                                      angle_exp.src.x, angle_exp.src.y, angle_exp.src.z,
                                      yaw_degrees_o, angle_exp.yaw));
          if (pitch_degrees_o !== angle_exp.pitch)
            report_mismatch($sformatf("pitch for (%0d,%0d,%0d): got %0d, want %0d",
                                      angle_exp.src.x, angle_exp.src.y, angle_exp.src.z,
                                      pitch_degrees_o, angle_exp.pitch));
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item and no result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o === 1'b1) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int xr;
    int yr;
    int zr;
    // Planar part zero: z positive, zero and negative.
    add_vector(0, 0, 0);
    add_vector(0, 0, 1);
    add_vector(0, 0, -1);
    add_vector(0, 0, 32767);
    add_vector(0, 0, -32768);
    // Axis directions and field extremes.
    add_vector(32767, 0, 0);
    add_vector(-32768, 0, 0);
    add_vector(0, 32767, 0);
    add_vector(0, -32768, 0);
    add_vector(1, 0, 0);
    add_vector(-1, 0, 0);
    add_vector(0, 1, 0);
    add_vector(0, -1, 0);
    add_vector(-32768, -32768, -32768);
    add_vector(32767, 32767, 32767);
    add_vector(-1, -1, -1);
    add_vector(1, 1, 1);
    add_vector(-32768, 32767, 0);
    add_vector(32767, -32768, -32768);
    // Negative x, with yaw near 180.
    add_vector(-5, 0, 7);
    add_vector(-32768, 1, 0);
    add_vector(-32768, -1, 3);
    // Angles just below a full turn that round up to 360 and wrap to zero.
    add_vector(32767, -1, 0);
    add_vector(32767, 0, -1);
    add_vector(32767, -1, -1);
    // Random vectors, a share of them with the planar part forced to zero.
    for (int n = 0; n < RandomItems; n++) begin
      xr = int'(rand_component());
      yr = int'(rand_component());
      zr = int'(rand_component());
      if ($urandom_range(0, 11) == 0) begin
        xr = 0;
        yr = 0;
      end
      add_vector(xr, yr, zr);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (vec_pending.size() != 0 || start || angle_q.size() != 0) @(posedge clk_i);
    repeat (2 * ResultLatency) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
